@@ rtl/dfs_pkg.sv @@
// ----------------------------------------------------------------------------
// dfs_pkg
// Types and constants shared by the distance shade pipeline.
// ----------------------------------------------------------------------------
package dfs_pkg;

  // configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;

  typedef enum logic {
    REG_REACH = 1'b0,
    REG_GAIN  = 1'b1
  } dfs_reg_e;

  localparam logic [23:0] REACH_RST = 24'd2048;
  localparam logic [15:0] GAIN_RST  = 16'd4096;

  // divider depths: weight quotient is below 2^17, channel quotient below 2^8
  localparam int unsigned WDIV_STEPS = 17;
  localparam int unsigned CDIV_STEPS = 8;

  // floor(x/3) for x < 2^25 as (x * DIV3_MUL) >> DIV3_SHIFT
  localparam int unsigned DIV3_SHIFT = 26;
  localparam logic [24:0] DIV3_MUL   = 25'd22369622;

  // gain product scale (Q1.16 weight times Q4.12 gain)
  localparam int unsigned PULL_SHIFT = 28;

  typedef struct packed {
    logic [23:0] reach;
    logic [15:0] gain;
  } dfs_cfg_t;

  // item as it travels down the pipeline; each stage fills its own fields
  typedef struct packed {
    logic [23:0]           color;
    logic                  cond;   // flashlight compensation applies
    logic [23:0]           dv0;    // divisor before compensation
    logic [23:0]           diff;   // reach - distance
    logic [16:0]           light;
    logic [23:0]           wrem;   // weight divider remainder
    logic [16:0]           wnum;   // weight dividend bits still to shift in
    logic [16:0]           wq;     // weight quotient
    logic [23:0]           mag;    // |dv0 - one|
    logic                  eneg;   // dv0 below one
    logic [40:0]           prod;   // mag * weight
    logic [56:0]           prod2;  // mag * weight * gain
    logic                  pass;   // final divisor at most one
    logic [29:0]           dv;     // final divisor when not passing
    logic [2:0][29:0]      crem;   // channel remainders, red at 2
    logic [2:0][7:0]       clo;    // channel dividend bits still to shift in
    logic [2:0][7:0]       cq;     // channel quotients
  } dfs_item_t;

endpackage

@@ rtl/dfs_in_if.sv @@
// ----------------------------------------------------------------------------
// dfs_in_if
// Pixel input channel: valid/ready with the shading request payload.
// ----------------------------------------------------------------------------
interface dfs_in_if;
  logic        valid;
  logic        ready;
  logic        shadows_on;
  logic        flashlight_on;
  logic [23:0] color_in;
  logic [23:0] distance;
  logic [16:0] light_weight;

  modport source (
    output valid, shadows_on, flashlight_on, color_in, distance, light_weight,
    input  ready
  );
  modport sink (
    input  valid, shadows_on, flashlight_on, color_in, distance, light_weight,
    output ready
  );
endinterface

@@ rtl/dfs_out_if.sv @@
// ----------------------------------------------------------------------------
// dfs_out_if
// Pixel output channel: valid/ready with the shaded color.
// ----------------------------------------------------------------------------
interface dfs_out_if;
  logic        valid;
  logic        ready;
  logic [23:0] color_out;

  modport source (
    output valid, color_out,
    input  ready
  );
  modport sink (
    input  valid, color_out,
    output ready
  );
endinterface

@@ rtl/dfs_cfg.sv @@
// ----------------------------------------------------------------------------
// dfs_cfg
// APB-style register file holding the flashlight range and boost.
// ----------------------------------------------------------------------------
module dfs_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dfs_pkg::APB_AW-1:0]    paddr,
  input  logic [dfs_pkg::APB_DW-1:0]    pwdata,
  output logic [dfs_pkg::APB_DW-1:0]    prdata,
  output logic                          pready,
  output dfs_pkg::dfs_cfg_t             cfg_o
);
  import dfs_pkg::*;

  logic [23:0] range_q;
  logic [15:0] boost_q;
  logic        wr_en;
  dfs_reg_e    reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_sel = dfs_reg_e'(paddr[2]);

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= REACH_RST;
      boost_q <= GAIN_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_REACH: range_q <= pwdata[23:0];
        REG_GAIN:  boost_q <= pwdata[15:0];
        default:   range_q <= range_q;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (reg_sel)
      REG_REACH: prdata = APB_DW'(range_q);
      REG_GAIN:  prdata = APB_DW'(boost_q);
      default:   prdata = '0;
    endcase
  end

  assign cfg_o.reach = range_q;
  assign cfg_o.gain  = boost_q;

endmodule

@@ rtl/dfs_stage.sv @@
// ----------------------------------------------------------------------------
// dfs_stage
// One pipeline register with valid/ready; an empty stage fills even while
// the stages after it stall.
// ----------------------------------------------------------------------------
module dfs_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  dfs_pkg::dfs_item_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output dfs_pkg::dfs_item_t data_o
);
  import dfs_pkg::*;

  logic      valid_q;
  dfs_item_t data_q;

  assign ready_o = ~valid_q | ready_i;

  // occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      data_q <= data_i;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ rtl/dfs_wcell.sv @@
// ----------------------------------------------------------------------------
// dfs_wcell
// One restoring step of the flashlight weight divide by the flashlight reach.
// ----------------------------------------------------------------------------
module dfs_wcell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [23:0]        range_i,
  input  logic               valid_i,
  output logic               ready_o,
  input  dfs_pkg::dfs_item_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output dfs_pkg::dfs_item_t data_o
);
  import dfs_pkg::*;

  logic [24:0] trial;
  logic [24:0] diff;
  logic        ge;
  dfs_item_t   nxt;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    trial = {data_i.wrem, data_i.wnum[16]};
    diff  = trial - {1'b0, range_i};
    ge    = trial >= {1'b0, range_i};
    nxt      = data_i;
    nxt.wrem = ge ? diff[23:0] : trial[23:0];
    nxt.wnum = {data_i.wnum[15:0], 1'b0};
    nxt.wq   = {data_i.wq[15:0], ge};
  end

  dfs_stage u_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .ready_o (ready_o),
    .data_i  (nxt),
    .valid_o (valid_o),
    .ready_i (ready_i),
    .data_o  (data_o)
  );

endmodule

@@ rtl/dfs_ccell.sv @@
// ----------------------------------------------------------------------------
// dfs_ccell
// One restoring step of the three channel divides by the final divisor.
// ----------------------------------------------------------------------------
module dfs_ccell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  dfs_pkg::dfs_item_t data_i,
  output logic               valid_o,
  input  logic               ready_i,
  output dfs_pkg::dfs_item_t data_o
);
  import dfs_pkg::*;

  logic [2:0][30:0] trial;
  logic [2:0][30:0] diff;
  logic [2:0]       ge;
  dfs_item_t        nxt;

  // red, green and blue step side by side
  always_comb begin
    nxt = data_i;
    for (int i = 0; i < 3; i++) begin
      trial[i]    = {data_i.crem[i], data_i.clo[i][7]};
      diff[i]     = trial[i] - {1'b0, data_i.dv};
      ge[i]       = trial[i] >= {1'b0, data_i.dv};
      nxt.crem[i] = ge[i] ? diff[i][29:0] : trial[i][29:0];
      nxt.clo[i]  = {data_i.clo[i][6:0], 1'b0};
      nxt.cq[i]   = {data_i.cq[i][6:0], ge[i]};
    end
  end

  dfs_stage u_stage (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (valid_i),
    .ready_o (ready_o),
    .data_i  (nxt),
    .valid_o (valid_o),
    .ready_i (ready_i),
    .data_o  (data_o)
  );

endmodule

@@ rtl/distance_flashlight_shade_unit.sv @@
// ----------------------------------------------------------------------------
// distance_flashlight_shade_unit
// Darkens a pixel color by distance, with flashlight compensation.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i takes one item per clock while ready (color, distance, light weight,
//   mode bits); pix_o returns each item's shaded color in order, one per item.
//   The flashlight reach and gain registers sit on the APB port at 0x0 and
//   0x4; write them only while no item is in flight.
// Pipeline: one register per stage, in order:
//   divisor setup (2), 17 weight divider cells, pull multiply and apply (3),
//   8 channel divider cells, and the output register.
// Throughput: one item per clock sustained while pix_o.ready stays high;
//   every stage is a cell of the chain and hands its item on each cycle.
// Reset: all stages empty, registers at 2048 (reach) and 4096 (gain).
// Stall: when pix_o.ready is low the output holds; each stage keeps
//   filling until it is occupied, so pix_i.ready falls only once the whole
//   chain is full.
// ----------------------------------------------------------------------------
module distance_flashlight_shade_unit #(
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dfs_in_if.sink                        pix_i,
  dfs_out_if.source                     pix_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dfs_pkg::APB_AW-1:0]    paddr,
  input  logic [dfs_pkg::APB_DW-1:0]    pwdata,
  output logic [dfs_pkg::APB_DW-1:0]    prdata,
  output logic                          pready
);
  import dfs_pkg::*;

  localparam logic [23:0] ONE   = 24'(1) << FRAC_BITS;
  localparam logic [30:0] ONE_W = 31'(ONE);

  dfs_cfg_t  cfg;

  // front stages
  dfs_item_t a_d, a_q, b_d, b_q, c_d, c_q, d_d, d_q, e_d, e_q, o_d, o_q;
  logic      a_v, b_v, c_v, d_v, e_v, o_v;
  logic      b_rdy, c_rdy, d_rdy, e_rdy, o_rdy;

  // cell chains
  logic      w_v [WDIV_STEPS+1];
  logic      w_r [WDIV_STEPS+1];
  dfs_item_t w_d [WDIV_STEPS+1];
  logic      k_v [CDIV_STEPS+1];
  logic      k_r [CDIV_STEPS+1];
  dfs_item_t k_d [CDIV_STEPS+1];

  logic [49:0]        div3_prod;
  logic [28:0]        pull;
  logic signed [30:0] dv_s;
  logic [2:0][23:0]   cshift;

  dfs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage A: shadow divisor 2d/3, range test and distance to range
  always_comb begin
    div3_prod = 50'({pix_i.distance, 1'b0}) * 50'(DIV3_MUL);
    a_d       = '0;
    a_d.color = pix_i.color_in;
    a_d.light = pix_i.light_weight;
    a_d.dv0   = pix_i.shadows_on ? div3_prod[DIV3_SHIFT +: 24] : ONE;
    a_d.diff  = cfg.reach - pix_i.distance;
    a_d.cond  = pix_i.flashlight_on && (pix_i.light_weight != '0) &&
                (pix_i.distance < cfg.reach);
  end

  dfs_stage u_stg_a (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (pix_i.valid), .ready_o (pix_i.ready), .data_i (a_d),
    .valid_o (a_v), .ready_i (b_rdy), .data_o (a_q)
  );

  // stage B: weight dividend and excess over one
  always_comb begin
    logic [40:0] num;
    num      = 41'(a_q.diff) * 41'(a_q.light);
    b_d      = a_q;
    b_d.wrem = num[40:17];
    b_d.wnum = num[16:0];
    b_d.wq   = '0;
    b_d.eneg = a_q.dv0 < ONE;
    b_d.mag  = (a_q.dv0 < ONE) ? (ONE - a_q.dv0) : (a_q.dv0 - ONE);
  end

  dfs_stage u_stg_b (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (a_v), .ready_o (b_rdy), .data_i (b_d),
    .valid_o (w_v[0]), .ready_i (w_r[0]), .data_o (w_d[0])
  );

  // weight divider chain, one quotient bit per cell
  for (genvar i = 0; i < WDIV_STEPS; i++) begin : g_wdiv
    dfs_wcell u_wcell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .range_i (cfg.reach),
      .valid_i (w_v[i]),
      .ready_o (w_r[i]),
      .data_i  (w_d[i]),
      .valid_o (w_v[i+1]),
      .ready_i (w_r[i+1]),
      .data_o  (w_d[i+1])
    );
  end
  assign w_r[WDIV_STEPS] = c_rdy;

  // stage C: excess times weight, weight zero when compensation is off
  always_comb begin
    c_d      = w_d[WDIV_STEPS];
    c_d.prod = 41'(w_d[WDIV_STEPS].mag) *
               41'(w_d[WDIV_STEPS].cond ? w_d[WDIV_STEPS].wq : 17'd0);
  end

  dfs_stage u_stg_c (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (w_v[WDIV_STEPS]), .ready_o (c_rdy), .data_i (c_d),
    .valid_o (c_v), .ready_i (d_rdy), .data_o (c_q)
  );

  // stage D: times gain
  always_comb begin
    d_d       = c_q;
    d_d.prod2 = 57'(c_q.prod) * 57'(cfg.gain);
  end

  dfs_stage u_stg_d (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (c_v), .ready_o (d_rdy), .data_i (d_d),
    .valid_o (d_v), .ready_i (e_rdy), .data_o (d_q)
  );

  // stage E: apply the pull toward one, set up channel dividends
  always_comb begin
    pull = d_q.prod2[PULL_SHIFT +: 29];
    if (d_q.eneg) begin
      dv_s = $signed({7'd0, d_q.dv0}) + $signed({2'd0, pull});
    end else begin
      dv_s = $signed({7'd0, d_q.dv0}) - $signed({2'd0, pull});
    end
    e_d      = d_q;
    e_d.pass = dv_s <= $signed(ONE_W);
    e_d.dv   = dv_s[29:0];
    for (int i = 0; i < 3; i++) begin
      cshift[i]    = 24'(d_q.color[8*i +: 8]) << FRAC_BITS;
      e_d.crem[i]  = 30'(cshift[i][23:8]);
      e_d.clo[i]   = cshift[i][7:0];
      e_d.cq[i]    = '0;
    end
  end

  dfs_stage u_stg_e (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (d_v), .ready_o (e_rdy), .data_i (e_d),
    .valid_o (k_v[0]), .ready_i (k_r[0]), .data_o (k_d[0])
  );

  // channel divider chain, one quotient bit per cell
  for (genvar i = 0; i < CDIV_STEPS; i++) begin : g_cdiv
    dfs_ccell u_ccell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (k_v[i]),
      .ready_o (k_r[i]),
      .data_i  (k_d[i]),
      .valid_o (k_v[i+1]),
      .ready_i (k_r[i+1]),
      .data_o  (k_d[i+1])
    );
  end
  assign k_r[CDIV_STEPS] = o_rdy;

  // output register: pass through or repacked quotients
  always_comb begin
    o_d = k_d[CDIV_STEPS];
    if (!k_d[CDIV_STEPS].pass) begin
      o_d.color = {k_d[CDIV_STEPS].cq[2], k_d[CDIV_STEPS].cq[1],
                   k_d[CDIV_STEPS].cq[0]};
    end
  end

  dfs_stage u_stg_o (
    .clk_i (clk_i), .rst_ni (rst_ni),
    .valid_i (k_v[CDIV_STEPS]), .ready_o (o_rdy), .data_i (o_d),
    .valid_o (o_v), .ready_i (pix_o.ready), .data_o (o_q)
  );

  assign pix_o.valid     = o_v;
  assign pix_o.color_out = o_q.color;

endmodule

@@ sim/distance_flashlight_shade_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// distance_flashlight_shade_unit_tb
// Streams pixels through the shade unit under random idling on both sides
// and several flashlight reach / gain settings. Each accepted pixel is
// shaded by a local fixed-point predictor, and the outputs are checked in
// order against those expected colors.
// ----------------------------------------------------------------------------
module distance_flashlight_shade_unit_tb;
  import dfs_pkg::*;

  localparam int unsigned FRAC_BITS    = 8;
  localparam int unsigned PULL_Q       = 28;   // weight * gain fraction bits
  localparam int unsigned DRAIN_CYCLES = 40;   // pipeline is 31 deep
  localparam int unsigned MAX_PRINTS   = 100;

  typedef struct packed {
    logic        shadows_on;
    logic        flashlight_on;
    logic [23:0] color_in;
    logic [23:0] distance;
    logic [16:0] light_weight;
  } pixel_t;

  typedef struct packed {
    pixel_t      px;
    logic [23:0] color;
  } shade_t;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [APB_AW-1:0]   paddr;
  logic [APB_DW-1:0]   pwdata;
  logic [APB_DW-1:0]   prdata;
  logic                pready;

  dfs_in_if  pix_in ();
  dfs_out_if pix_out ();

  distance_flashlight_shade_unit #(
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_in),
    .pix_o   (pix_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // local copy of the register file
  logic [23:0] cfg_range;
  logic [15:0] cfg_boost;

  pixel_t      pixel_q[$];   // pixels waiting to be sent
  shade_t      shade_q[$];   // expected colors of accepted pixels
  int unsigned mismatch_cnt;

  pixel_t      cur_px;
  pixel_t      drv_px;
  shade_t      want;
  int unsigned send_gap;
  int unsigned stall_left;
  bit          send_calm;
  bit          recv_calm;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // hard limit on run length
  initial begin
    #(64'd10_000_000);
    $display("RESULT: ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // helpers
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatch_cnt++;
    // keep the log bounded when things go badly wrong
    if (mismatch_cnt <= MAX_PRINTS) $display("%0t ns: %s", $time, what);
  endtask

  // shaded color of one pixel under the current register values
  function automatic logic [23:0] predict_color(input pixel_t px);
    longint          one;
    longint          dv;
    longint          excess;
    longint          pull;
    longint unsigned wgt;
    longint unsigned wb;
    longint unsigned mag;
    longint unsigned chan;
    logic [23:0]     res;
    int              ch;
    one = longint'(64'd1 << FRAC_BITS);
    dv  = one;
    if (px.shadows_on) dv = $signed((64'(px.distance) * 64'd2) / 64'd3);
    // flashlight pulls the divisor back toward one
    if (px.flashlight_on && px.light_weight != '0 && px.distance < cfg_range) begin
      wgt    = ((64'(cfg_range) - 64'(px.distance)) * 64'(px.light_weight)) / 64'(cfg_range);
      wb     = wgt * 64'(cfg_boost);
      excess = dv - one;
      mag    = (excess < 0) ? -excess : excess;
      pull   = $signed((mag * wb) >> PULL_Q);
      dv     = (excess < 0) ? dv + pull : dv - pull;
    end
    if (dv <= one) return px.color_in;
    for (ch = 0; ch < 3; ch++) begin
      chan            = 64'(px.color_in[ch*8 +: 8]) << FRAC_BITS;
      res[ch*8 +: 8]  = 8'(chan / $unsigned(dv));
    end
    return res;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int unsigned idle_len();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic pixel_t mk_pixel(input logic sh, input logic fl, input logic [23:0] col,
                                      input logic [23:0] dst, input logic [16:0] lw);
    pixel_t px;
    px.shadows_on    = sh;
    px.flashlight_on = fl;
    px.color_in      = col;
    px.distance      = dst;
    px.light_weight  = lw;
    return px;
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.shadows_on    = ($urandom_range(0, 99) < 85);
    px.flashlight_on = ($urandom_range(0, 99) < 70);
    case ($urandom_range(0, 9))
      0:       px.color_in = 24'hFFFFFF;
      1:       px.color_in = 24'h000000;
      default: px.color_in = 24'($urandom);
    endcase
    // distance: whole range, below the flashlight reach, near one, near reach, or up to 2^8..2^24
    case ($urandom_range(0, 4))
      0: px.distance = 24'($urandom);
      1: px.distance = (cfg_range == '0) ? 24'($urandom_range(0, 255))
                                         : 24'($urandom_range(0, 32'(cfg_range) - 1));
      2: px.distance = 24'($urandom_range(0, 1024));
      3: px.distance = 24'(32'(cfg_range) + $urandom_range(0, 2) - 1);
      default: px.distance = 24'($urandom_range(0, 32'd1 << $urandom_range(8, 24)));
    endcase
    case ($urandom_range(0, 9))
      0:       px.light_weight = '0;
      1:       px.light_weight = 17'd65536;
      2:       px.light_weight = 17'($urandom_range(65537, 131071));
      default: px.light_weight = 17'($urandom_range(1, 65535));
    endcase
    return px;
  endfunction

  task automatic write_reg(input dfs_reg_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_REACH: cfg_range = val[23:0];
      REG_GAIN:  cfg_boost = val[15:0];
      default: ;
    endcase
  endtask

  // wait for every queued pixel to be sent and shaded, then let the pipe drain
  task automatic wait_idle();
    do @(negedge clk_i); while (pixel_q.size() != 0 || shade_q.size() != 0 || pix_in.valid);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_random(input int unsigned count, input bit drain_often);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      pixel_q.push_back(rand_pixel());
      // sender holds off until everything sent so far has come back
      if (drain_often && (k % 40 == 39)) wait_idle();
    end
    wait_idle();
  endtask

  // ---------------------------------------------------------------------------
  // pixel driver
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_in.valid <= 1'b0;
      send_gap     <= 0;
      send_calm    <= 1'b0;
    end else begin
      if (pix_in.valid && pix_in.ready)
        shade_q.push_back('{px: cur_px, color: predict_color(cur_px)});
      if ($urandom_range(0, 127) == 0) send_calm <= !send_calm;
      if (!pix_in.valid || pix_in.ready) begin
        if (send_gap != 0) begin
          pix_in.valid <= 1'b0;
          send_gap     <= send_gap - 1;
        end else if (pixel_q.size() != 0) begin
          drv_px                = pixel_q.pop_front();
          cur_px               <= drv_px;
          pix_in.valid         <= 1'b1;
          pix_in.shadows_on    <= drv_px.shadows_on;
          pix_in.flashlight_on <= drv_px.flashlight_on;
          pix_in.color_in      <= drv_px.color_in;
          pix_in.distance      <= drv_px.distance;
          pix_in.light_weight  <= drv_px.light_weight;
          send_gap             <= send_calm ? 0 : idle_len();
        end else begin
          pix_in.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and output stalls
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pix_out.ready <= 1'b0;
      stall_left    <= 0;
      recv_calm     <= 1'b0;
    end else begin
      if (pix_out.valid && pix_out.ready) begin
        if (shade_q.size() == 0) begin
          report_mismatch($sformatf("color_out %06h with no pixel outstanding",
                                    pix_out.color_out));
        end else begin
          want = shade_q.pop_front();
          if (pix_out.color_out !== want.color)
            report_mismatch($sformatf(
              "color_out %06h, want %06h (sh %0b fl %0b col %06h dist %06h lw %05h)",
              pix_out.color_out, want.color, want.px.shadows_on, want.px.flashlight_on,
              want.px.color_in, want.px.distance, want.px.light_weight));
        end
      end
      if ($urandom_range(0, 127) == 0) recv_calm <= !recv_calm;
      if (stall_left != 0) begin
        pix_out.ready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else begin
        pix_out.ready <= 1'b1;
        stall_left    <= recv_calm ? 0 : idle_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned ph;
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    pix_in.valid         = 1'b0;
    pix_in.shadows_on    = 1'b0;
    pix_in.flashlight_on = 1'b0;
    pix_in.color_in      = '0;
    pix_in.distance      = '0;
    pix_in.light_weight  = '0;
    pix_out.ready        = 1'b0;
    cfg_range            = 24'd2048;
    cfg_boost            = 16'd4096;
    mismatch_cnt         = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed pixels at the reset register values
    pixel_q.push_back(mk_pixel(0, 0, 24'hFFFFFF, 24'd0, 17'd0));        // shadows off
    pixel_q.push_back(mk_pixel(0, 1, 24'h123456, 24'd100, 17'd65536));  // off, light on
    pixel_q.push_back(mk_pixel(1, 0, 24'hFFFFFF, 24'd0, 17'd0));        // zero divisor
    pixel_q.push_back(mk_pixel(1, 0, 24'hFFFFFF, 24'd384, 17'd0));      // divisor exactly one
    pixel_q.push_back(mk_pixel(1, 0, 24'hFFFFFF, 24'd386, 17'd0));      // just above one
    pixel_q.push_back(mk_pixel(1, 0, 24'hFFFFFF, 24'hFFFFFF, 17'd0));   // farthest
    pixel_q.push_back(mk_pixel(1, 0, 24'h000000, 24'd5000, 17'd0));
    pixel_q.push_back(mk_pixel(1, 0, 24'hFF0000, 24'd600, 17'd0));
    pixel_q.push_back(mk_pixel(1, 0, 24'h00FF00, 24'd600, 17'd0));
    pixel_q.push_back(mk_pixel(1, 0, 24'h0000FF, 24'd600, 17'd0));
    pixel_q.push_back(mk_pixel(1, 1, 24'hA5A5A5, 24'd1000, 17'd0));     // zero light weight
    pixel_q.push_back(mk_pixel(1, 1, 24'hA5A5A5, 24'd1000, 17'd65536));
    pixel_q.push_back(mk_pixel(1, 1, 24'hA5A5A5, 24'd2048, 17'd65536)); // at reach
    pixel_q.push_back(mk_pixel(1, 1, 24'hA5A5A5, 24'd2047, 17'd65536)); // just inside
    pixel_q.push_back(mk_pixel(1, 1, 24'hA5A5A5, 24'd4000, 17'd65536)); // beyond reach
    pixel_q.push_back(mk_pixel(1, 1, 24'h5A5A5A, 24'd100, 17'd131071)); // overshoot above one
    pixel_q.push_back(mk_pixel(1, 1, 24'h5A5A5A, 24'd1500, 17'd131071));
    pixel_q.push_back(mk_pixel(1, 1, 24'h5A5A5A, 24'd0, 17'd131071));
    pixel_q.push_back(mk_pixel(1, 1, 24'hFFFFFF, 24'd1, 17'd1));
    pixel_q.push_back(mk_pixel(0, 0, 24'h000000, 24'hFFFFFF, 17'd131071));
    pixel_q.push_back(mk_pixel(1, 1, 24'h7F7F7F, 24'd600, 17'd98304));
    wait_idle();

    // register settings, extremes first, then random ones
    for (ph = 0; ph < 7; ph++) begin
      case (ph)
        0: run_random(250, 1'b0);
        1: begin
          write_reg(REG_REACH, 32'd1);
          write_reg(REG_GAIN, 32'd0);
          run_random(200, 1'b0);
        end
        2: begin
          write_reg(REG_REACH, 32'hFFFFFF);
          write_reg(REG_GAIN, 32'hFFFF);
          // strong pull drives the divisor below one and below zero
          pixel_q.push_back(mk_pixel(1, 1, 24'hFFFFFF, 24'd1500, 17'd131071));
          pixel_q.push_back(mk_pixel(1, 1, 24'h808080, 24'd9000, 17'd65536));
          run_random(300, 1'b0);
        end
        3: begin
          // zero reach: never compensates
          write_reg(REG_REACH, 32'd0);
          write_reg(REG_GAIN, 32'd4096);
          run_random(50, 1'b0);
        end
        4: begin
          write_reg(REG_REACH, 32'($urandom_range(1, 4096)));
          write_reg(REG_GAIN, 32'($urandom_range(0, 65535)));
          run_random(300, 1'b0);
        end
        5: begin
          write_reg(REG_REACH, 32'($urandom_range(1, 24'hFFFFFF)));
          write_reg(REG_GAIN, 32'hFFFF);
          run_random(300, 1'b1);
        end
        default: begin
          write_reg(REG_REACH, 32'd2048);
          write_reg(REG_GAIN, 32'd4096);
          run_random(250, 1'b0);
        end
      endcase
    end

    if (shade_q.size() != 0)
      report_mismatch($sformatf("%0d expected colors never arrived", shade_q.size()));
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
